### rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, types and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package scp_pkg;

	localparam int COLUMNS     = 1024;
	localparam int HEIGHT_BITS = 16;
	localparam int LEFT_W      = 10;
	localparam int BWIDTH_W    = 11;
	localparam int EDGE_W      = 11;
	localparam int ADDR_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	// column counter: holds COLUMNS itself and any left + width sum
	localparam int CNT_W       = (ADDR_W + 1 > 12) ? ADDR_W + 1 : 12;

	localparam logic ACT_CLEAR = 1'b0;
	localparam logic ACT_PLACE = 1'b1;

	typedef logic [HEIGHT_BITS-1:0] height_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [EDGE_W-1:0]      edge_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture the input transaction
		logic sweep_init; // col = 0, stop = COLUMNS
		logic sweep_step; // write zero at col, advance
		logic wipe_ext;   // zero both extents
		logic rd_init;    // col = left, stop = clipped right edge, max = 0
		logic rd_step;    // read at col, advance
		logic wr_init;    // top = sat(max + height), col = left
		logic wr_step;    // write top at col, advance
		logic finish;     // update extents, load output register
	} scp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic col_done;   // column counter reached its stop
		logic out_free;   // output register can take a result this cycle
	} scp_sts_t;

endpackage

### rtl/scp_in_if.sv
// ----------------------------------------------------------------------------
// scp_in_if
// Request channel: one transaction is a clear or a block placement.
// ----------------------------------------------------------------------------
interface scp_in_if
	import scp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                action;
	logic [LEFT_W-1:0]   left_column;
	logic [BWIDTH_W-1:0] block_width;
	height_t             block_height;

	modport source (output valid, action, left_column, block_width, block_height,
		input ready);
	modport sink (input valid, action, left_column, block_width, block_height,
		output ready);
endinterface

### rtl/scp_out_if.sv
// ----------------------------------------------------------------------------
// scp_out_if
// Result channel: bottom, top and running extents of one transaction.
// ----------------------------------------------------------------------------
interface scp_out_if
	import scp_pkg::*;
();
	logic    valid;
	logic    ready;
	height_t placed_bottom;
	height_t placed_top;
	height_t extent_height;
	edge_t   extent_width;

	modport source (output valid, placed_bottom, placed_top, extent_height,
		extent_width, input ready);
	modport sink (input valid, placed_bottom, placed_top, extent_height,
		extent_width, output ready);
endinterface

### rtl/scp_datapath.sv
// ----------------------------------------------------------------------------
// scp_datapath
// Skyline memory, column counter, max/saturation logic, extents, output reg.
// ----------------------------------------------------------------------------
module scp_datapath
	import scp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  scp_cmd_t       cmd,
	output scp_sts_t       sts,
	scp_in_if.sink         req,
	scp_out_if.source      rsp
);

	height_t              mem [COLUMNS];
	height_t              rd_data_q;
	logic                 rd_vld_q;

	logic                 action_q;
	logic [LEFT_W-1:0]    left_q;
	logic [BWIDTH_W-1:0]  width_q;
	height_t              height_q;

	cnt_t                 col_q;
	cnt_t                 stop_q;
	height_t              max_q;
	height_t              top_q;
	height_t              tallest_q;
	edge_t                widest_q;

	logic                 out_vld_q;
	height_t              bottom_o_q;
	height_t              top_o_q;
	height_t              ext_h_q;
	edge_t                ext_w_q;

	cnt_t                 right_sum;
	cnt_t                 stop_d;
	logic [HEIGHT_BITS:0] top_sum;
	height_t              top_d;
	edge_t                edge_d;
	height_t              tallest_d;
	edge_t                widest_d;
	logic                 mem_we;
	height_t              mem_wdata;

	// right edge of the block, and the stop column clipped to the store
	assign right_sum = cnt_t'(left_q) + cnt_t'(width_q);
	assign stop_d    = (right_sum > cnt_t'(COLUMNS)) ? cnt_t'(COLUMNS) : right_sum;
	assign edge_d    = (right_sum > cnt_t'({EDGE_W{1'b1}})) ? {EDGE_W{1'b1}}
		: right_sum[EDGE_W-1:0];

	assign top_sum = {1'b0, max_q} + {1'b0, height_q};
	assign top_d   = top_sum[HEIGHT_BITS] ? {HEIGHT_BITS{1'b1}} : top_sum[HEIGHT_BITS-1:0];

	assign tallest_d = (top_q > tallest_q) ? top_q : tallest_q;
	assign widest_d  = (edge_d > widest_q) ? edge_d : widest_q;

	assign mem_we    = cmd.sweep_step | cmd.wr_step;
	assign mem_wdata = cmd.wr_step ? top_q : '0;

	assign sts.col_done = (col_q >= stop_q);
	assign sts.out_free = !out_vld_q || rsp.ready;

	// single-port skyline store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[col_q[ADDR_W-1:0]] <= mem_wdata;
		end
		rd_data_q <= mem[col_q[ADDR_W-1:0]];
	end

	// item, counter and working values
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req.action;
			left_q   <= req.left_column;
			width_q  <= req.block_width;
			height_q <= req.block_height;
		end
		if (cmd.sweep_init) begin
			col_q  <= '0;
			stop_q <= cnt_t'(COLUMNS);
		end else if (cmd.rd_init) begin
			col_q  <= cnt_t'(left_q);
			stop_q <= stop_d;
		end else if (cmd.wr_init) begin
			col_q  <= cnt_t'(left_q);
		end else if (cmd.sweep_step || cmd.rd_step || cmd.wr_step) begin
			col_q  <= col_q + cnt_t'(1);
		end
		if (cmd.rd_init) begin
			max_q <= '0;
		end else if (rd_vld_q && rd_data_q > max_q) begin
			max_q <= rd_data_q;
		end
		if (cmd.wr_init) begin
			top_q <= top_d;
		end
		if (cmd.finish) begin
			bottom_o_q <= (action_q == ACT_PLACE) ? max_q : '0;
			top_o_q    <= (action_q == ACT_PLACE) ? top_q : '0;
			ext_h_q    <= (action_q == ACT_PLACE) ? tallest_d : '0;
			ext_w_q    <= (action_q == ACT_PLACE) ? widest_d : '0;
		end
	end

	// control and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q  <= 1'b0;
			tallest_q <= '0;
			widest_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.rd_step;
			if (cmd.wipe_ext) begin
				tallest_q <= '0;
				widest_q  <= '0;
			end else if (cmd.finish && action_q == ACT_PLACE) begin
				tallest_q <= tallest_d;
				widest_q  <= widest_d;
			end
			if (cmd.finish) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.placed_bottom = bottom_o_q;
	assign rsp.placed_top    = top_o_q;
	assign rsp.extent_height = ext_h_q;
	assign rsp.extent_width  = ext_w_q;

endmodule

### rtl/scp_ctrl.sv
// ----------------------------------------------------------------------------
// scp_ctrl
// Sequencer: boot sweep, clear sweep, read scan, write scan, result hand-off.
// ----------------------------------------------------------------------------
module scp_ctrl
	import scp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_action,
	input  scp_sts_t sts,
	output logic     req_ready,
	output scp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_BOOT_SET,
		S_BOOT,
		S_IDLE,
		S_CLR_SET,
		S_CLEAR,
		S_RD_SET,
		S_READ,
		S_WRITE,
		S_DONE,
		S_TOP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_BOOT_SET: begin
				cmd.sweep_init = 1'b1;
				state_d        = S_BOOT;
			end
			S_BOOT: begin
				if (sts.col_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.sweep_step = 1'b1;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_action == ACT_PLACE) ? S_RD_SET : S_CLR_SET;
				end
			end
			S_CLR_SET: begin
				cmd.sweep_init = 1'b1;
				cmd.wipe_ext   = 1'b1;
				state_d        = S_CLEAR;
			end
			S_CLEAR: begin
				if (sts.col_done) begin
					state_d = S_DONE;
				end else begin
					cmd.sweep_step = 1'b1;
				end
			end
			S_RD_SET: begin
				cmd.rd_init = 1'b1;
				state_d     = S_READ;
			end
			S_READ: begin
				// last read data folds into the max on the edge that leaves
				if (sts.col_done) begin
					state_d = S_TOP;
				end else begin
					cmd.rd_step = 1'b1;
				end
			end
			S_TOP: begin
				cmd.wr_init = 1'b1;
				state_d     = S_WRITE;
			end
			S_WRITE: begin
				if (sts.col_done) begin
					state_d = S_DONE;
				end else begin
					cmd.wr_step = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT_SET;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/skyline_contour_placer_unit.sv
// ----------------------------------------------------------------------------
// skyline_contour_placer_unit
// Skyline contour placer: clear or place one block per transaction.
// ----------------------------------------------------------------------------
// Place: a read scan and then a write scan over the covered columns inside
//   the store; one memory port, one column per cycle, for the read scan and
//   again for the write scan. Throughput: one item at a time.
// Clear: a zeroing sweep over the whole store.
// Reset: clears control at once, then a boot sweep zeroes the skyline;
//   req.ready stays low until it ends.
// A finished result sits in the output register; the next request is taken
//   while it waits.
// ----------------------------------------------------------------------------
module skyline_contour_placer_unit
	import scp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	scp_in_if.sink    req,
	scp_out_if.source rsp
);

	scp_cmd_t cmd;
	scp_sts_t sts;

	// controller sees only handshake/opcode bits of the request
	scp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.sts        (sts),
		.req_ready  (req.ready),
		.cmd        (cmd)
	);

	// skyline store, scans, extents and the result register
	scp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

### tb/tb_skyline_contour_placer_unit.sv
// ----------------------------------------------------------------------------
// tb_skyline_contour_placer_unit
// Self-checking bench: clears and block placements against a skyline predictor.
// ----------------------------------------------------------------------------
// A queue of placement and clear transactions is built up front. It starts
// with a directed set: store edges, saturation, zero width and clears with
// junk fields. Random episodes follow, each one a clear and then a run of
// placements, mostly in one column window so that blocks pile up. A negedge driver
// feeds the request channel with random gaps. A negedge process stalls the
// result channel at random. A posedge scoreboard predicts each accepted
// request and checks every result, field by field, in order.
// ----------------------------------------------------------------------------
module tb_skyline_contour_placer_unit;
	import scp_pkg::*;

	localparam int unsigned HEIGHT_TOP = (1 << HEIGHT_BITS) - 1;
	localparam int unsigned EDGE_TOP   = (1 << EDGE_W) - 1;
	localparam int unsigned RANDOM_ITEMS = 2000;

	typedef struct packed {
		logic                action;
		logic [LEFT_W-1:0]   left_column;
		logic [BWIDTH_W-1:0] block_width;
		height_t             block_height;
	} placement_t;

	// drain_first: the sender holds this one back until nothing is outstanding
	typedef struct {
		placement_t item;
		bit         drain_first;
	} queued_request_t;

	typedef struct packed {
		height_t placed_bottom;
		height_t placed_top;
		height_t extent_height;
		edge_t   extent_width;
	} placement_result_t;

	logic clk;
	logic arst_n;

	scp_in_if  req_if ();
	scp_out_if rsp_if ();

	skyline_contour_placer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// Predictor copy of the skyline and both running extents
	height_t skyline_col [COLUMNS];
	height_t tallest_top;
	edge_t   widest_edge;

	queued_request_t   pending_requests [$];
	placement_result_t expected_results [$];

	int unsigned mismatches = 0;
	logic        req_taken  = 1'b0;
	int unsigned send_gap   = 0;
	int unsigned stall_left = 0;
	bit          sender_calm   = 1'b0;
	bit          receiver_calm = 1'b0;

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: far beyond the slowest legal run of this stimulus
	initial begin
		#40_000_000;
		$display("Timeout: %0d requests queued, %0d results outstanding",
			pending_requests.size(), expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor: one transaction in, the result it must produce out.
	// A clear wipes everything and answers all zeros. A placement takes the
	// highest column under it as its bottom (columns past the store are
	// skipped), flattens those columns to the saturated top, then bumps the
	// extents. Zero width touches no column, so the bottom is zero.
	// ------------------------------------------------------------------------
	function automatic placement_result_t place_on_skyline(logic action,
			logic [LEFT_W-1:0] left, logic [BWIDTH_W-1:0] width, height_t height);
		placement_result_t    res;
		int unsigned          stop_col;
		int unsigned          right_edge;
		int unsigned          col;
		height_t              floor_level;
		height_t              top_level;
		logic [HEIGHT_BITS:0] raised;
		res = '0;
		if (action == ACT_CLEAR) begin
			foreach (skyline_col[c])
				skyline_col[c] = '0;
			tallest_top = '0;
			widest_edge = '0;
			return res;
		end
		stop_col = int'(left) + int'(width);
		if (stop_col > COLUMNS)
			stop_col = COLUMNS;
		floor_level = '0;
		for (col = left; col < stop_col; col++)
			if (skyline_col[col] > floor_level)
				floor_level = skyline_col[col];
		raised = {1'b0, floor_level} + {1'b0, height};
		top_level = raised[HEIGHT_BITS] ? height_t'(HEIGHT_TOP) : raised[HEIGHT_BITS-1:0];
		for (col = left; col < stop_col; col++)
			skyline_col[col] = top_level;
		if (top_level > tallest_top)
			tallest_top = top_level;
		// right edge saturates before it is compared
		right_edge = int'(left) + int'(width);
		if (right_edge > EDGE_TOP)
			right_edge = EDGE_TOP;
		if (right_edge > widest_edge)
			widest_edge = edge_t'(right_edge);
		res.placed_bottom = floor_level;
		res.placed_top    = top_level;
		res.extent_height = tallest_top;
		res.extent_width  = widest_edge;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Mostly no gap, often a short one, now and then a long one
	function automatic int unsigned idle_length(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 97)
			return $urandom_range(1, 4);
		return $urandom_range(12, 90);
	endfunction

	task automatic queue_request(input logic action, input int unsigned left,
			input int unsigned width, input int unsigned height, input bit drain);
		queued_request_t q;
		q.item.action       = action;
		q.item.left_column  = LEFT_W'(left);
		q.item.block_width  = BWIDTH_W'(width);
		q.item.block_height = height_t'(height);
		q.drain_first       = drain;
		pending_requests = {pending_requests, q};
	endtask

	// ------------------------------------------------------------------------
	// Request driver (falling edge). A new transaction goes out only once the
	// previous one was taken at the last rising edge; a gap runs after each
	// acceptance. A drain_first entry waits for the result queue to empty.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		queued_request_t next_req;
		if (!arst_n) begin
			req_if.valid        <= 1'b0;
			req_if.action       <= ACT_CLEAR;
			req_if.left_column  <= '0;
			req_if.block_width  <= '0;
			req_if.block_height <= '0;
		end else if (!req_if.valid || req_taken) begin
			if (send_gap != 0) begin
				req_if.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_requests.size() == 0 ||
					(pending_requests[0].drain_first && expected_results.size() != 0)) begin
				req_if.valid <= 1'b0;
			end else begin
				next_req = pending_requests.pop_front();
				req_if.valid        <= 1'b1;
				req_if.action       <= next_req.item.action;
				req_if.left_column  <= next_req.item.left_column;
				req_if.block_width  <= next_req.item.block_width;
				req_if.block_height <= next_req.item.block_height;
				send_gap <= idle_length(sender_calm);
				// flip between gappy and back-to-back stretches
				if ($urandom_range(0, 39) == 0)
					sender_calm <= !sender_calm;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result back-pressure (falling edge): random stalls, with calm stretches
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left != 0) begin
			rsp_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_if.ready <= 1'b1;
			stall_left <= idle_length(receiver_calm);
			if ($urandom_range(0, 49) == 0)
				receiver_calm <= !receiver_calm;
		end
	end

	// ------------------------------------------------------------------------
	// Scoreboard (rising edge). The result side is checked before the request
	// side is predicted: a result leaving on the same edge as a new request
	// always belongs to an older transaction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		placement_result_t want;
		if (arst_n) begin
			if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing outstanding: bottom %0d top %0d",
						rsp_if.placed_bottom, rsp_if.placed_top);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					compare_field("placed_bottom", want.placed_bottom, rsp_if.placed_bottom);
					compare_field("placed_top", want.placed_top, rsp_if.placed_top);
					compare_field("extent_height", want.extent_height, rsp_if.extent_height);
					compare_field("extent_width", want.extent_width, rsp_if.extent_width);
				end
			end
			if (req_if.valid && req_if.ready === 1'b1) begin
				want = place_on_skyline(req_if.action, req_if.left_column,
					req_if.block_width, req_if.block_height);
				expected_results = {expected_results, want};
			end
		end
		req_taken <= arst_n && req_if.valid && req_if.ready === 1'b1;
	end

	// ------------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		int unsigned queued;
		int unsigned run_len;
		int unsigned base;
		int unsigned span;
		int unsigned r;
		int unsigned left;
		int unsigned width;
		int unsigned height;
		bit          drain;

		arst_n = 1'b0;

		foreach (skyline_col[c])
			skyline_col[c] = '0;
		tallest_top = '0;
		widest_edge = '0;

		// Directed part
		queue_request(ACT_PLACE, 0, 1, 0, 1'b0);             // fresh store, zero height
		queue_request(ACT_PLACE, 0, COLUMNS, 1, 1'b0);       // whole store to one
		queue_request(ACT_PLACE, 1023, COLUMNS, HEIGHT_TOP, 1'b0); // runs off the end, saturates
		queue_request(ACT_PLACE, 1023, 1, 5, 1'b0);          // on top of a saturated column
		queue_request(ACT_PLACE, 512, 0, 300, 1'b0);         // zero width: bottom is zero
		queue_request(ACT_PLACE, 1020, 10, 7, 1'b0);         // partly past the store
		queue_request(ACT_PLACE, 0, 512, 16'h8000, 1'b0);
		queue_request(ACT_PLACE, 256, 512, 16'h8000, 1'b0);  // overlap, sum overflows
		queue_request(ACT_CLEAR, 1023, COLUMNS, HEIGHT_TOP, 1'b1); // clear, junk fields ignored
		queue_request(ACT_PLACE, 5, 3, 10, 1'b0);
		queue_request(ACT_PLACE, 10'h2AA, 11'h155, 16'hAAAA, 1'b0); // alternating bits
		queue_request(ACT_PLACE, 10'h155, 11'h2AA, 16'h5555, 1'b0);
		queue_request(ACT_PLACE, 0, 0, 0, 1'b0);             // all zero fields
		queue_request(ACT_CLEAR, 0, 0, 0, 1'b0);
		queue_request(ACT_PLACE, 700, 40, 0, 1'b0);          // zero height after clear
		queue_request(ACT_PLACE, 690, 20, 1, 1'b0);

		// Random episodes: a clear, then placements crowded into one window so
		// the contour grows tall and ragged; a few strays land anywhere.
		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			drain = (queued == 0) || ($urandom_range(0, 3) == 0);
			queue_request(ACT_CLEAR, $urandom_range(0, 1023), $urandom_range(0, COLUMNS),
				$urandom, drain);
			queued++;
			// a fifth of the windows hug the end of the store
			base    = ($urandom_range(0, 4) == 0) ? $urandom_range(960, 1023) :
				$urandom_range(0, 1023);
			span    = $urandom_range(16, 128);
			run_len = $urandom_range(20, 150);
			repeat (run_len) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					width = 0;
				else if (r < 6)
					width = $urandom_range(65, COLUMNS);
				else if (r < 7)
					width = COLUMNS;
				else if (r < 30)
					width = $urandom_range(17, 64);
				else
					width = $urandom_range(1, 16);
				left = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) :
					(base + $urandom_range(0, span)) % COLUMNS;
				r = $urandom_range(0, 99);
				if (r < 2)
					height = HEIGHT_TOP;
				else if (r < 4)
					height = 0;
				else if (r < 70)
					height = $urandom_range(0, 255);
				else if (r < 90)
					height = $urandom_range(0, 4095);
				else
					height = $urandom_range(0, HEIGHT_TOP);
				// an occasional clear in the middle of a run
				if ($urandom_range(0, 99) < 2)
					queue_request(ACT_CLEAR, left, width, height, 1'b0);
				else
					queue_request(ACT_PLACE, left, width, height, 1'b0);
				queued++;
			end
		end

		// Reset: held, then released on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Everything sent, everything answered, then a quiet spell to catch
		// any stray result transaction
		while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (2 * COLUMNS + 8) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### skyline_contour_placer_unit.f
rtl/scp_pkg.sv
rtl/scp_in_if.sv
rtl/scp_out_if.sv
rtl/scp_datapath.sv
rtl/scp_ctrl.sv
rtl/skyline_contour_placer_unit.sv
tb/tb_skyline_contour_placer_unit.sv
